// File: design/qrs_pkg.sv
// qrs_pkg: shared widths, codes and context types of the quadratic root solver
// depends on nothing; used by the solver core

package qrs_pkg;

   // word format of the coefficients and roots
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int THR_BITS  = 16;
   localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(1);
   localparam int CODE_BITS = 2;

   // discriminant and its square root
   localparam int D_BITS  = 2 * WORD_BITS + 2;
   localparam int S_BITS  = D_BITS / 2;
   localparam int N_BITS  = S_BITS + 2;
   // divider dividend and divisor
   localparam int NUM_BITS = N_BITS - 1 + FRAC_BITS;
   localparam int DEN_BITS = WORD_BITS + 1;
   // second square root, of quotient scaled by one more fraction
   localparam int R2_RAD_BITS = 2 * WORD_BITS;
   localparam int R2_BITS     = R2_RAD_BITS / 2;
   // signed quotient before saturation
   localparam int X_BITS = NUM_BITS + 1;

   // root count codes
   localparam logic [CODE_BITS-1:0] CNT_NONE = 2'd0;
   localparam logic [CODE_BITS-1:0] CNT_ONE  = 2'd1;
   localparam logic [CODE_BITS-1:0] CNT_TWO  = 2'd2;
   localparam logic [CODE_BITS-1:0] CNT_INF  = 2'd3;

   // solve case codes
   localparam logic [CODE_BITS-1:0] KIND_LINEAR = 2'd0;
   localparam logic [CODE_BITS-1:0] KIND_QUAD   = 2'd1;
   localparam logic [CODE_BITS-1:0] KIND_BZERO  = 2'd2;
   localparam logic [CODE_BITS-1:0] KIND_ABZERO = 2'd3;

   // how the roots are formed at the end of the pipe
   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_LIN,
      MODE_QUAD,
      MODE_BZ
   } mode_type;

   // context riding along the discriminant square root
   typedef struct packed {
      mode_type               mode;
      logic [CODE_BITS-1:0]   kind;
      logic [CODE_BITS-1:0]   count;
      logic                   a_neg;
      logic                   b_neg;
      logic                   c_neg;
      logic [WORD_BITS-1:0]   b;
      logic [WORD_BITS-1:0]   ma;
      logic [WORD_BITS-1:0]   mb;
      logic [WORD_BITS-1:0]   mc;
   } ctx1_type;

   // context riding along the divider
   typedef struct packed {
      mode_type               mode;
      logic [CODE_BITS-1:0]   kind;
      logic [CODE_BITS-1:0]   count;
      logic                   neg_a;
      logic                   neg_b;
   } ctx2_type;

   // context riding along the second square root
   typedef struct packed {
      ctx2_type               ctx;
      logic [NUM_BITS-1:0]    qa;
      logic [NUM_BITS-1:0]    qb;
   } ctx3_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]   val;
      logic                   ovf;
   } sat_type;

   // clamp a wide signed value to the word range
   function automatic sat_type saturate(input logic signed [X_BITS-1:0] x);
      logic signed [X_BITS-1:0] wmax;
      logic signed [X_BITS-1:0] wmin;
      sat_type                  r;
      wmax = {{(X_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
      wmin = {{(X_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
      if (x > wmax) begin
         r.val = {1'b0, {(WORD_BITS-1){1'b1}}};
         r.ovf = 1'b1;
      end else if (x < wmin) begin
         r.val = {1'b1, {(WORD_BITS-1){1'b0}}};
         r.ovf = 1'b1;
      end else begin
         r.val = x[WORD_BITS-1:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

endpackage

// File: design/qrs_sqrt_cell.sv
// qrs_sqrt_cell: one digit of a pipelined integer square root (two radicand bits a cell)
// depends on nothing; chained by the solver core

module qrs_sqrt_cell #(
   parameter int RAD_BITS  = 66,
   parameter int SIDE_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        prev_valid,
   input  logic [RAD_BITS-1:0]         prev_rad,
   input  logic [RAD_BITS/2+1:0]       prev_rem,
   input  logic [RAD_BITS/2-1:0]       prev_root,
   input  logic [SIDE_BITS-1:0]        prev_side,
   output logic                        valid_ff,
   output logic [RAD_BITS-1:0]         rad_ff,
   output logic [RAD_BITS/2+1:0]       rem_ff,
   output logic [RAD_BITS/2-1:0]       root_ff,
   output logic [SIDE_BITS-1:0]        side_ff
);

   localparam int RT = RAD_BITS / 2;
   localparam int RM = RT + 2;

   logic [RM-1:0]       rem_sh;
   logic [RM-1:0]       trial;
   logic                ge;
   logic [RAD_BITS-1:0] rad_in;
   logic [RM-1:0]       rem_in;
   logic [RT-1:0]       root_in;

   // bring down the next bit pair and try root*4+1
   always_comb begin
      rem_sh  = {prev_rem[RM-3:0], prev_rad[RAD_BITS-1:RAD_BITS-2]};
      trial   = {prev_root, 2'b01};
      ge      = (rem_sh >= trial);
      rem_in  = ge ? (rem_sh - trial) : rem_sh;
      root_in = {prev_root[RT-2:0], ge};
      rad_in  = {prev_rad[RAD_BITS-3:0], 2'b00};
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= prev_valid;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      side_ff <= prev_side;
   end

endmodule

// File: design/qrs_div_cell.sv
// qrs_div_cell: one quotient bit of two restoring division lanes
// depends on nothing; chained by the solver core

module qrs_div_cell #(
   parameter int NUM_BITS  = 50,
   parameter int DEN_BITS  = 33,
   parameter int SIDE_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             prev_valid,
   input  logic [1:0][NUM_BITS-1:0]         prev_num,
   input  logic [1:0][DEN_BITS-1:0]         prev_rem,
   input  logic [1:0][DEN_BITS-1:0]         prev_den,
   input  logic [SIDE_BITS-1:0]             prev_side,
   output logic                             valid_ff,
   output logic [1:0][NUM_BITS-1:0]         num_ff,
   output logic [1:0][DEN_BITS-1:0]         rem_ff,
   output logic [1:0][DEN_BITS-1:0]         den_ff,
   output logic [SIDE_BITS-1:0]             side_ff
);

   logic [1:0][DEN_BITS:0]   sh;
   logic [1:0][DEN_BITS:0]   diff;
   logic [1:0]               ge;
   logic [1:0][NUM_BITS-1:0] num_in;
   logic [1:0][DEN_BITS-1:0] rem_in;

   // shift in the next dividend bit, subtract divisor when it fits
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         sh[l]     = {prev_rem[l], prev_num[l][NUM_BITS-1]};
         diff[l]   = sh[l] - {1'b0, prev_den[l]};
         ge[l]     = (sh[l] >= {1'b0, prev_den[l]});
         rem_in[l] = ge[l] ? diff[l][DEN_BITS-1:0] : sh[l][DEN_BITS-1:0];
         num_in[l] = {prev_num[l][NUM_BITS-2:0], ge[l]};
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= prev_valid;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= prev_den;
      side_ff <= prev_side;
   end

endmodule

// File: design/quadratic_root_solver_core.sv
// quadratic_root_solver_core: pipelined solver of a*x^2 + b*x + c = 0 in signed Q16.16
// depends on qrs_pkg, qrs_sqrt_cell and qrs_div_cell
//
// Usage:
//  - input: a coefficient word (req_coef_a/b/c) is taken at each clock edge with start
//    high and busy low; busy stays low, so a new word may enter every cycle
//  - output: each word gives exactly one result word, shown for one cycle with
//    rsp_strobe high; the receiver cannot stall, results leave in input order
//  - pipeline: 33 discriminant square root cells, 50 divider cells (two lanes) and
//    32 square root cells for the b zero case, plus four setup and output stages
//  - throughput: one word per cycle
//  - csr channel: writes the 16-bit linear ratio threshold, always ready; write it
//    only while no word is in flight
//  - reset: synchronous, clears all valid bits and sets the threshold to 1

module quadratic_root_solver_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [qrs_pkg::THR_BITS-1:0]         csr_data,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [qrs_pkg::WORD_BITS-1:0] req_coef_a,
   input  logic signed [qrs_pkg::WORD_BITS-1:0] req_coef_b,
   input  logic signed [qrs_pkg::WORD_BITS-1:0] req_coef_c,
   output logic                                 rsp_strobe,
   output logic [qrs_pkg::CODE_BITS-1:0]        rsp_root_count,
   output logic [qrs_pkg::CODE_BITS-1:0]        rsp_solve_case,
   output logic signed [qrs_pkg::WORD_BITS-1:0] rsp_root_one,
   output logic signed [qrs_pkg::WORD_BITS-1:0] rsp_root_two,
   output logic                                 rsp_root_overflow
);

   import qrs_pkg::*;

   localparam int SQ1_CELLS = S_BITS;
   localparam int DIV_CELLS = NUM_BITS;
   localparam int SQ2_CELLS = R2_BITS;
   localparam int SIDE1 = $bits(ctx1_type);
   localparam int SIDE2 = $bits(ctx2_type);
   localparam int SIDE3 = $bits(ctx3_type);
   localparam int W = WORD_BITS;

   // threshold register
   logic [THR_BITS-1:0] thr_ff;
   logic                in_fire;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;
   assign in_fire   = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_data;
      end
   end

   // stage 1: magnitudes and products
   logic [W-1:0]     ma_in, mb_in, mc_in;
   logic [2*W-1:0]   p_in, q_in;
   logic [W+THR_BITS-1:0] t_in;

   logic                  s1_valid_ff;
   logic                  s1_a_neg_ff, s1_b_neg_ff, s1_c_neg_ff;
   logic                  s1_a_zero_ff, s1_b_zero_ff, s1_c_zero_ff;
   logic [W-1:0]          s1_b_ff, s1_ma_ff, s1_mb_ff, s1_mc_ff;
   logic [2*W-1:0]        s1_p_ff, s1_q_ff;
   logic [W+THR_BITS-1:0] s1_t_ff;

   always_comb begin
      ma_in = req_coef_a[W-1] ? (~req_coef_a + W'(1)) : req_coef_a;
      mb_in = req_coef_b[W-1] ? (~req_coef_b + W'(1)) : req_coef_b;
      mc_in = req_coef_c[W-1] ? (~req_coef_c + W'(1)) : req_coef_c;
      p_in  = (2*W)'(mb_in) * (2*W)'(mb_in);
      q_in  = (2*W)'(ma_in) * (2*W)'(mc_in);
      t_in  = (W+THR_BITS)'(thr_ff) * (W+THR_BITS)'(mb_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_fire;
      end
      s1_a_neg_ff  <= req_coef_a[W-1];
      s1_b_neg_ff  <= req_coef_b[W-1];
      s1_c_neg_ff  <= req_coef_c[W-1];
      s1_a_zero_ff <= (req_coef_a == '0);
      s1_b_zero_ff <= (req_coef_b == '0);
      s1_c_zero_ff <= (req_coef_c == '0);
      s1_b_ff      <= req_coef_b;
      s1_ma_ff     <= ma_in;
      s1_mb_ff     <= mb_in;
      s1_mc_ff     <= mc_in;
      s1_p_ff      <= p_in;
      s1_q_ff      <= q_in;
      s1_t_ff      <= t_in;
   end

   // stage 2: linear test, discriminant, case split
   logic              lin;
   logic              same_sign;
   logic              disc_neg;
   logic [D_BITS-1:0] p_wide, q4_wide, disc_in;
   ctx1_type          ctx1_in;

   logic              s2_valid_ff;
   logic [D_BITS-1:0] s2_rad_ff;
   ctx1_type          s2_ctx_ff;

   always_comb begin
      lin       = ({s1_ma_ff, {FRAC_BITS{1'b0}}} < s1_t_ff);
      same_sign = (s1_a_neg_ff == s1_c_neg_ff);
      p_wide    = {2'b00, s1_p_ff};
      q4_wide   = {s1_q_ff, 2'b00};
      disc_neg  = same_sign && (q4_wide > p_wide);
      disc_in   = same_sign ? (p_wide - q4_wide) : (p_wide + q4_wide);

      ctx1_in.a_neg = s1_a_neg_ff;
      ctx1_in.b_neg = s1_b_neg_ff;
      ctx1_in.c_neg = s1_c_neg_ff;
      ctx1_in.b     = s1_b_ff;
      ctx1_in.ma    = s1_ma_ff;
      ctx1_in.mb    = s1_mb_ff;
      ctx1_in.mc    = s1_mc_ff;
      ctx1_in.mode  = MODE_NONE;
      ctx1_in.kind  = KIND_ABZERO;
      ctx1_in.count = s1_c_zero_ff ? CNT_INF : CNT_NONE;
      if (!s1_b_zero_ff) begin
         if (lin || s1_a_zero_ff) begin
            ctx1_in.kind  = KIND_LINEAR;
            ctx1_in.mode  = MODE_LIN;
            ctx1_in.count = CNT_ONE;
         end else begin
            ctx1_in.kind  = KIND_QUAD;
            ctx1_in.mode  = disc_neg ? MODE_NONE : MODE_QUAD;
            ctx1_in.count = CNT_NONE;
         end
      end else if (!s1_a_zero_ff) begin
         ctx1_in.kind = KIND_BZERO;
         if (s1_c_zero_ff) begin
            ctx1_in.count = CNT_ONE;
         end else if (!same_sign) begin
            ctx1_in.mode  = MODE_BZ;
            ctx1_in.count = CNT_TWO;
         end else begin
            ctx1_in.count = CNT_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_rad_ff <= disc_in;
      s2_ctx_ff <= ctx1_in;
   end

   // discriminant square root chain
   logic                 sq1_valid [0:SQ1_CELLS];
   logic [D_BITS-1:0]    sq1_rad   [0:SQ1_CELLS];
   logic [S_BITS+1:0]    sq1_rem   [0:SQ1_CELLS];
   logic [S_BITS-1:0]    sq1_root  [0:SQ1_CELLS];
   logic [SIDE1-1:0]     sq1_side  [0:SQ1_CELLS];

   assign sq1_valid[0] = s2_valid_ff;
   assign sq1_rad[0]   = s2_rad_ff;
   assign sq1_rem[0]   = '0;
   assign sq1_root[0]  = '0;
   assign sq1_side[0]  = s2_ctx_ff;

   for (genvar i = 0; i < SQ1_CELLS; i++) begin : g_sq1
      qrs_sqrt_cell #(
         .RAD_BITS  (D_BITS),
         .SIDE_BITS (SIDE1)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_valid (sq1_valid[i]),
         .prev_rad   (sq1_rad[i]),
         .prev_rem   (sq1_rem[i]),
         .prev_root  (sq1_root[i]),
         .prev_side  (sq1_side[i]),
         .valid_ff   (sq1_valid[i+1]),
         .rad_ff     (sq1_rad[i+1]),
         .rem_ff     (sq1_rem[i+1]),
         .root_ff    (sq1_root[i+1]),
         .side_ff    (sq1_side[i+1])
      );
   end

   // divider operand setup
   ctx1_type                  c1;
   logic signed [N_BITS-1:0]  neg_b, s_wide, n1, n2;
   logic [N_BITS-2:0]         m1, m2;
   logic [1:0][NUM_BITS-1:0]  num_in;
   logic [1:0][DEN_BITS-1:0]  den_in;
   ctx2_type                  ctx2_in;

   logic                      pr_valid_ff;
   logic [1:0][NUM_BITS-1:0]  pr_num_ff;
   logic [1:0][DEN_BITS-1:0]  pr_den_ff;
   ctx2_type                  pr_ctx_ff;

   always_comb begin
      c1     = sq1_side[SQ1_CELLS];
      neg_b  = N_BITS'(0) - {{(N_BITS-W){c1.b[W-1]}}, c1.b};
      s_wide = {2'b00, sq1_root[SQ1_CELLS]};
      n1     = neg_b + s_wide;
      n2     = neg_b - s_wide;
      m1     = n1[N_BITS-1] ? (N_BITS-1)'(-n1) : n1[N_BITS-2:0];
      m2     = n2[N_BITS-1] ? (N_BITS-1)'(-n2) : n2[N_BITS-2:0];

      ctx2_in.mode  = c1.mode;
      ctx2_in.kind  = c1.kind;
      ctx2_in.count = c1.count;
      ctx2_in.neg_a = 1'b0;
      ctx2_in.neg_b = 1'b0;
      num_in[0] = {{(NUM_BITS-W-FRAC_BITS){1'b0}}, c1.mc, {FRAC_BITS{1'b0}}};
      num_in[1] = '0;
      den_in[0] = DEN_BITS'(1);
      den_in[1] = DEN_BITS'(1);
      case (c1.mode)
         MODE_LIN: begin
            den_in[0]     = {1'b0, c1.mb};
            ctx2_in.neg_a = ~(c1.c_neg ^ c1.b_neg);
         end
         MODE_BZ: begin
            den_in[0] = {1'b0, c1.ma};
         end
         MODE_QUAD: begin
            num_in[0]     = {m1, {FRAC_BITS{1'b0}}};
            num_in[1]     = {m2, {FRAC_BITS{1'b0}}};
            den_in[0]     = {c1.ma, 1'b0};
            den_in[1]     = {c1.ma, 1'b0};
            ctx2_in.neg_a = n1[N_BITS-1] ^ c1.a_neg;
            ctx2_in.neg_b = n2[N_BITS-1] ^ c1.a_neg;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else begin
         pr_valid_ff <= sq1_valid[SQ1_CELLS];
      end
      pr_num_ff <= num_in;
      pr_den_ff <= den_in;
      pr_ctx_ff <= ctx2_in;
   end

   // divider chain, two lanes
   logic                      dv_valid [0:DIV_CELLS];
   logic [1:0][NUM_BITS-1:0]  dv_num   [0:DIV_CELLS];
   logic [1:0][DEN_BITS-1:0]  dv_rem   [0:DIV_CELLS];
   logic [1:0][DEN_BITS-1:0]  dv_den   [0:DIV_CELLS];
   logic [SIDE2-1:0]          dv_side  [0:DIV_CELLS];

   assign dv_valid[0] = pr_valid_ff;
   assign dv_num[0]   = pr_num_ff;
   assign dv_rem[0]   = '0;
   assign dv_den[0]   = pr_den_ff;
   assign dv_side[0]  = pr_ctx_ff;

   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
      qrs_div_cell #(
         .NUM_BITS  (NUM_BITS),
         .DEN_BITS  (DEN_BITS),
         .SIDE_BITS (SIDE2)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_valid (dv_valid[i]),
         .prev_num   (dv_num[i]),
         .prev_rem   (dv_rem[i]),
         .prev_den   (dv_den[i]),
         .prev_side  (dv_side[i]),
         .valid_ff   (dv_valid[i+1]),
         .num_ff     (dv_num[i+1]),
         .rem_ff     (dv_rem[i+1]),
         .den_ff     (dv_den[i+1]),
         .side_ff    (dv_side[i+1])
      );
   end

   // second square root chain, for the b zero case
   ctx3_type                 ctx3_in;
   logic [NUM_BITS-1:0]      qa_last;
   logic                     sq2_valid [0:SQ2_CELLS];
   logic [R2_RAD_BITS-1:0]   sq2_rad   [0:SQ2_CELLS];
   logic [R2_BITS+1:0]       sq2_rem   [0:SQ2_CELLS];
   logic [R2_BITS-1:0]       sq2_root  [0:SQ2_CELLS];
   logic [SIDE3-1:0]         sq2_side  [0:SQ2_CELLS];

   always_comb begin
      qa_last     = dv_num[DIV_CELLS][0];
      ctx3_in.ctx = dv_side[DIV_CELLS];
      ctx3_in.qa  = qa_last;
      ctx3_in.qb  = dv_num[DIV_CELLS][1];
   end

   assign sq2_valid[0] = dv_valid[DIV_CELLS];
   assign sq2_rad[0]   = {qa_last[R2_RAD_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
   assign sq2_rem[0]   = '0;
   assign sq2_root[0]  = '0;
   assign sq2_side[0]  = ctx3_in;

   for (genvar i = 0; i < SQ2_CELLS; i++) begin : g_sq2
      qrs_sqrt_cell #(
         .RAD_BITS  (R2_RAD_BITS),
         .SIDE_BITS (SIDE3)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_valid (sq2_valid[i]),
         .prev_rad   (sq2_rad[i]),
         .prev_rem   (sq2_rem[i]),
         .prev_root  (sq2_root[i]),
         .prev_side  (sq2_side[i]),
         .valid_ff   (sq2_valid[i+1]),
         .rad_ff     (sq2_rad[i+1]),
         .rem_ff     (sq2_rem[i+1]),
         .root_ff    (sq2_root[i+1]),
         .side_ff    (sq2_side[i+1])
      );
   end

   // result assembly: sign, saturate, count
   ctx3_type                 c3;
   logic signed [X_BITS-1:0] xa, xb, xr;
   sat_type                  sat_a, sat_b, sat_p, sat_n;
   logic                     eq;
   logic [CODE_BITS-1:0]     count_in;
   logic [W-1:0]             r1_in, r2_in;
   logic                     ovf_in;

   logic                     out_valid_ff;
   logic [CODE_BITS-1:0]     out_count_ff, out_kind_ff;
   logic [W-1:0]             out_r1_ff, out_r2_ff;
   logic                     out_ovf_ff;

   always_comb begin
      c3    = sq2_side[SQ2_CELLS];
      xa    = c3.ctx.neg_a ? (X_BITS'(0) - {1'b0, c3.qa}) : {1'b0, c3.qa};
      xb    = c3.ctx.neg_b ? (X_BITS'(0) - {1'b0, c3.qb}) : {1'b0, c3.qb};
      xr    = {{(X_BITS-R2_BITS){1'b0}}, sq2_root[SQ2_CELLS]};
      sat_a = saturate(xa);
      sat_b = saturate(xb);
      sat_p = saturate(xr);
      sat_n = saturate(X_BITS'(0) - xr);
      eq    = (xa == xb);

      count_in = c3.ctx.count;
      r1_in    = '0;
      r2_in    = '0;
      ovf_in   = 1'b0;
      unique case (c3.ctx.mode)
         MODE_NONE: begin
         end
         MODE_LIN: begin
            count_in = CNT_ONE;
            r1_in    = sat_a.val;
            ovf_in   = sat_a.ovf;
         end
         MODE_QUAD: begin
            count_in = eq ? CNT_ONE : CNT_TWO;
            r1_in    = sat_a.val;
            r2_in    = eq ? '0 : sat_b.val;
            ovf_in   = sat_a.ovf | (~eq & sat_b.ovf);
         end
         MODE_BZ: begin
            count_in = CNT_TWO;
            r1_in    = sat_p.val;
            r2_in    = sat_n.val;
            ovf_in   = sat_p.ovf | sat_n.ovf;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= sq2_valid[SQ2_CELLS];
      end
      out_count_ff <= count_in;
      out_kind_ff  <= c3.ctx.kind;
      out_r1_ff    <= r1_in;
      out_r2_ff    <= r2_in;
      out_ovf_ff   <= ovf_in;
   end

   assign rsp_strobe        = out_valid_ff;
   assign rsp_root_count    = out_count_ff;
   assign rsp_solve_case    = out_kind_ff;
   assign rsp_root_one      = out_r1_ff;
   assign rsp_root_two      = out_r2_ff;
   assign rsp_root_overflow = out_ovf_ff;

endmodule

// File: bench/quadratic_root_solver_core_test.sv
// quadratic_root_solver_core_test: self-checking bench of the quadratic root solver core
// depends on qrs_pkg and quadratic_root_solver_core; predicts every result word in wide
// integer arithmetic and compares it field by field in input order
`timescale 1ns / 100ps

module quadratic_root_solver_core_test;
   import qrs_pkg::*;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [CODE_BITS-1:0] count;
      logic [CODE_BITS-1:0] kind;
      logic [WORD_BITS-1:0] root_one;
      logic [WORD_BITS-1:0] root_two;
      logic                 ovf;
   } roots_type;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 130;

   logic                        clock;
   logic                        reset;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [THR_BITS-1:0]         csr_data;
   logic                        start;
   logic                        busy;
   logic signed [WORD_BITS-1:0] req_coef_a;
   logic signed [WORD_BITS-1:0] req_coef_b;
   logic signed [WORD_BITS-1:0] req_coef_c;
   logic                        rsp_strobe;
   logic [CODE_BITS-1:0]        rsp_root_count;
   logic [CODE_BITS-1:0]        rsp_solve_case;
   logic signed [WORD_BITS-1:0] rsp_root_one;
   logic signed [WORD_BITS-1:0] rsp_root_two;
   logic                        rsp_root_overflow;

   roots_type           pending_roots[$];
   logic [THR_BITS-1:0] ratio_threshold;
   int                  error_count;
   int                  idle_cycles;
   bit                  burst_mode;

   quadratic_root_solver_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .start             (start),
      .busy              (busy),
      .req_coef_a        (req_coef_a),
      .req_coef_b        (req_coef_b),
      .req_coef_c        (req_coef_c),
      .rsp_strobe        (rsp_strobe),
      .rsp_root_count    (rsp_root_count),
      .rsp_solve_case    (rsp_solve_case),
      .rsp_root_one      (rsp_root_one),
      .rsp_root_two      (rsp_root_two),
      .rsp_root_overflow (rsp_root_overflow)
   );

   // 8 ns clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // floor square root by bit trial
   function automatic wide_type floor_sqrt(input wide_type v);
      wide_type r;
      wide_type cand;
      r = 0;
      for (int i = 40; i >= 0; i--) begin
         cand = r | (wide_type'(1) <<< i);
         if (cand * cand <= v) r = cand;
      end
      return r;
   endfunction

   // clamp to the word range, flag on clamp
   function automatic logic [WORD_BITS-1:0] clamp_word(input wide_type v, inout logic ovf);
      wide_type wmax;
      wide_type wmin;
      wmax = (wide_type'(1) <<< (WORD_BITS - 1)) - 1;
      wmin = -(wide_type'(1) <<< (WORD_BITS - 1));
      if (v > wmax) begin
         ovf = 1'b1;
         return wmax[WORD_BITS-1:0];
      end
      if (v < wmin) begin
         ovf = 1'b1;
         return wmin[WORD_BITS-1:0];
      end
      return v[WORD_BITS-1:0];
   endfunction

   // expected roots of a*x^2 + b*x + c = 0 under the current threshold
   function automatic roots_type solve_roots(input logic signed [WORD_BITS-1:0] ca,
                                             input logic signed [WORD_BITS-1:0] cb,
                                             input logic signed [WORD_BITS-1:0] cc);
      roots_type s;
      wide_type  a, b, c, ma, mb, mc, one, disc, sq, x1, x2, quo;
      logic      ovf;
      a   = ca;
      b   = cb;
      c   = cc;
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      mc  = (c < 0) ? -c : c;
      one = wide_type'(1) <<< FRAC_BITS;
      ovf = 1'b0;
      s.count    = CNT_NONE;
      s.root_one = '0;
      s.root_two = '0;
      if (b != 0) begin
         if ((ma <<< FRAC_BITS) < wide_type'(ratio_threshold) * mb || a == 0) begin
            s.kind     = KIND_LINEAR;
            s.count    = CNT_ONE;
            s.root_one = clamp_word((-c * one) / b, ovf);
         end else begin
            s.kind = KIND_QUAD;
            disc   = b * b - 4 * a * c;
            if (disc >= 0) begin
               sq = floor_sqrt(disc);
               x1 = ((-b + sq) * one) / (2 * a);
               x2 = ((-b - sq) * one) / (2 * a);
               s.root_one = clamp_word(x1, ovf);
               if (x1 == x2) begin
                  s.count = CNT_ONE;
               end else begin
                  s.count    = CNT_TWO;
                  s.root_two = clamp_word(x2, ovf);
               end
            end
         end
      end else if (a != 0) begin
         s.kind = KIND_BZERO;
         if (c == 0) begin
            s.count = CNT_ONE;
         end else if ((a < 0) != (c < 0)) begin
            quo        = (mc <<< FRAC_BITS) / ma;
            sq         = floor_sqrt(quo <<< FRAC_BITS);
            s.count    = CNT_TWO;
            s.root_one = clamp_word(sq, ovf);
            s.root_two = clamp_word(-sq, ovf);
         end
      end else begin
         s.kind  = KIND_ABZERO;
         s.count = (c == 0) ? CNT_INF : CNT_NONE;
      end
      s.ovf = ovf;
      return s;
   endfunction

   // send one coefficient word, after a random pause unless in burst mode
   task automatic send_coefs(input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] b,
                             input logic [WORD_BITS-1:0] c);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      do @(posedge clock); while (busy);
      pending_roots.push_back(solve_roots(a, b, c));
   endtask

   // wait for every outstanding result word
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_roots.size() != 0) @(posedge clock);
   endtask

   // threshold write while idle
   task automatic write_threshold(input logic [THR_BITS-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid       <= 1'b0;
      ratio_threshold  = value;
   endtask

   // random coefficient from a mix of value classes
   function automatic logic [WORD_BITS-1:0] pick_coef();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return 32'h7fff_ffff;
         2: return 32'h8000_0000;
         3: return $urandom_range(0, 15) << FRAC_BITS;
         4: return -($urandom_range(0, 15) << FRAC_BITS);
         5: return $urandom_range(0, 255) - 128;
         6: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
         default: return $urandom;
      endcase
   endfunction

   // random item, shaped toward each solve case
   task automatic send_random_coefs();
      logic [WORD_BITS-1:0] a, b, c;
      a = pick_coef();
      b = pick_coef();
      c = pick_coef();
      case ($urandom_range(0, 7))
         0: b = '0;
         1: begin
            a = '0;
            b = '0;
         end
         2: a = '0;
         3: c = '0;
         default: ;
      endcase
      send_coefs(a, b, c);
   endtask

   // named special cases at reset threshold
   task automatic test_special_cases();
      send_coefs(32'h0, 32'h0, 32'h0);                // infinitely many
      send_coefs(32'h0, 32'h0, 32'h0001_0000);        // a and b zero, none
      send_coefs(32'h0001_0000, 32'h0, -32'sh0004_0000); // +/- 2
      send_coefs(32'h0001_0000, 32'h0, 32'h0004_0000);   // b zero, none
      send_coefs(-32'sh0005_0000, 32'h0, 32'h0);      // single zero root
      send_coefs(32'h7fff_ffff, 32'h0, -32'sh1);      // root below resolution
      send_coefs(32'h8000_0000, 32'h0, 32'h7fff_ffff);
      send_coefs(32'h1, 32'h0, 32'h8000_0000);        // b zero saturating roots
      send_coefs(32'h0, 32'h0001_0000, 32'h0002_0000); // linear
      send_coefs(32'h0, 32'h1, 32'h7fff_ffff);        // linear saturating
      send_coefs(32'h0, -32'sh1, 32'h8000_0000);
      send_coefs(32'h0001_0000, -32'sh0003_0000, 32'h0002_0000); // two roots
      send_coefs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);   // equal roots
      send_coefs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);   // negative disc
      send_coefs(32'h1, 32'h7fff_ffff, 32'h8000_0000);           // linear
      send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      send_coefs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_coefs(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
   endtask

   // threshold extremes and a random middle value, with zero a at zero threshold
   task automatic test_thresholds();
      logic [THR_BITS-1:0] thr_list[4];
      thr_list = '{16'h0, 16'hffff, 16'h0, 16'h1};
      thr_list[2] = THR_BITS'($urandom_range(2, 16'hfffe));
      foreach (thr_list[i]) begin
         write_threshold(thr_list[i]);
         send_coefs(32'h0, 32'h0003_0000, -32'sh0006_0000);
         send_coefs(32'h0000_8000, 32'h0001_0000, 32'h0000_4000);
         send_coefs(32'h0001_0000, 32'h0001_0000, 32'h0);
         repeat (15) send_random_coefs();
      end
   endtask

   // random words in chunks, with bursts and threshold changes
   task automatic test_random_stream();
      for (int chunk = 0; chunk < 8; chunk++) begin
         burst_mode = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 1)) write_threshold(THR_BITS'($urandom));
         repeat (45) send_random_coefs();
      end
      burst_mode = 1'b0;
   endtask

   // sender holds off until the pipe is empty, then resumes
   task automatic test_drain_pause();
      repeat (10) send_random_coefs();
      wait_drained();
      repeat (10) send_random_coefs();
   endtask

   // result checking against the oldest expectation
   always @(posedge clock) begin
      roots_type exp_r;
      if (!reset && rsp_strobe) begin
         if (pending_roots.size() == 0) begin
            $display("%0t: unexpected result word count=%0d case=%0d", $time,
                     rsp_root_count, rsp_solve_case);
            error_count++;
         end else begin
            exp_r = pending_roots.pop_front();
            if (rsp_root_count !== exp_r.count) begin
               $display("%0t: root_count expected %0d actual %0d", $time, exp_r.count,
                        rsp_root_count);
               error_count++;
            end
            if (rsp_solve_case !== exp_r.kind) begin
               $display("%0t: solve_case expected %0d actual %0d", $time, exp_r.kind,
                        rsp_solve_case);
               error_count++;
            end
            if (rsp_root_one !== exp_r.root_one) begin
               $display("%0t: root_one expected %h actual %h", $time, exp_r.root_one,
                        rsp_root_one);
               error_count++;
            end
            if (rsp_root_two !== exp_r.root_two) begin
               $display("%0t: root_two expected %h actual %h", $time, exp_r.root_two,
                        rsp_root_two);
               error_count++;
            end
            if (rsp_root_overflow !== exp_r.ovf) begin
               $display("%0t: root_overflow expected %0d actual %0d", $time, exp_r.ovf,
                        rsp_root_overflow);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // test sequence
   initial begin
      reset           = 1'b1;
      csr_valid       = 1'b0;
      csr_data        = '0;
      start           = 1'b0;
      req_coef_a      = '0;
      req_coef_b      = '0;
      req_coef_c      = '0;
      error_count     = 0;
      idle_cycles     = 0;
      burst_mode      = 1'b0;
      ratio_threshold = THR_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_special_cases();
      test_thresholds();
      test_drain_pause();
      test_random_stream();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_roots.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
